FILE: hw/rtl/spn_pkg.sv
// ----------------------------------------------------------------------------
// spn_pkg: shared types and constants of the next-hop search
// Request and result payloads, the link that runs along the cell chain, and
// the control word that the sequencer broadcasts to every cell.
// ----------------------------------------------------------------------------
package spn_pkg;

  localparam int unsigned JID_W  = 4;
  localparam int unsigned COST_W = 16;

  localparam logic [COST_W-1:0] NO_ROAD   = 16'hFFFF;
  localparam logic [COST_W-1:0] RSU_RESET = 16'h0008;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic [JID_W-1:0]  jid_t;
  typedef logic [COST_W-1:0] cost_t;

  typedef struct packed {
    logic  req_type;
    jid_t  from_junction;
    jid_t  to_junction;
    cost_t road_cost;
  } in_req_t;

  typedef struct packed {
    jid_t next_junction;
    logic found;
  } out_res_t;

  // Running minimum handed from cell to cell
  typedef struct packed {
    jid_t  idx;
    cost_t dval;
  } link_t;

  // Broadcast control from the sequencer
  typedef struct packed {
    logic  init;
    logic  settle;
    jid_t  settle_idx;
    cost_t bestd;
    logic  pick;
    jid_t  src;
    cost_t cost;
  } ctl_t;

endpackage

FILE: hw/rtl/spn_cell.sv
// ----------------------------------------------------------------------------
// spn_cell: one junction of the search chain
// Holds distance, parent and visited flag of its junction. When the sweep
// token reaches it, it relaxes its road from the settled junction (or checks
// its roadside unit bit) and folds itself into the running minimum.
// ----------------------------------------------------------------------------
module spn_cell
  import spn_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  jid_t  idx_i,
  input  logic  rsu_i,
  input  ctl_t  ctl_i,
  input  logic  tok_i,
  input  link_t link_i,
  output logic  tok_o,
  output link_t link_o,
  output jid_t  parent_o
);

  cost_t       dist_q, dist_d;
  jid_t        parent_q, parent_d;
  logic        done_q, done_d;
  logic        tok_q;
  link_t       link_q, link_d;
  logic [16:0] sum;
  cost_t       sat;
  logic        relax;
  logic        cand;
  cost_t       nd;

  // Saturating sum of settled distance and road cost.
  always_comb begin
    sum   = {1'b0, ctl_i.bestd} + {1'b0, ctl_i.cost};
    sat   = (sum >= {1'b0, NO_ROAD}) ? NO_ROAD : sum[15:0];
    relax = tok_i && !ctl_i.pick && !done_q && (ctl_i.cost != NO_ROAD) && (sat < dist_q);
    nd    = relax ? sat : dist_q;
    cand  = ctl_i.pick ? rsu_i : !done_q;
  end

  // Next state of the junction and of the running minimum.
  always_comb begin
    dist_d   = dist_q;
    parent_d = parent_q;
    done_d   = done_q;
    link_d   = link_q;
    if (ctl_i.init) begin
      dist_d   = (idx_i == ctl_i.src) ? '0 : NO_ROAD;
      parent_d = ctl_i.src;
      done_d   = ctl_i.settle && (ctl_i.settle_idx == idx_i);
    end else begin
      if (ctl_i.settle && (ctl_i.settle_idx == idx_i)) begin
        done_d = 1'b1;
      end
      if (relax) begin
        dist_d   = sat;
        parent_d = ctl_i.settle_idx;
      end
    end
    if (tok_i) begin
      link_d = (cand && (nd < link_i.dval)) ? link_t'{idx: idx_i, dval: nd} : link_i;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      tok_q  <= tok_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dist_q   <= dist_d;
    parent_q <= parent_d;
    link_q   <= link_d;
  end

  assign tok_o    = tok_q;
  assign link_o   = link_q;
  assign parent_o = parent_q;

endmodule

FILE: hw/rtl/shortest_path_next_hop.sv
// ----------------------------------------------------------------------------
// shortest_path_next_hop: next hop toward the nearest roadside unit
// Symmetric road cost store plus a chain of junction cells that run Dijkstra
// one column per cycle, pick the nearest unit and walk the parents back.
// ----------------------------------------------------------------------------
// A cost write gives no result. A query runs one sweep round per settled
// junction plus one unit pick round over the chain of N cells (N is the min
// of NUM_JUNCTIONS and 16), then walks the parents back to the first hop.
// Each round is one sweep of the cell chain fed by the single cost read port.
// One query at a time; the result strobe lasts one cycle and cannot be held.
// Reset empties the cost store (valid bits) and sets the unit mask to 0x0008.
module shortest_path_next_hop
  import spn_pkg::*;
#(
  parameter int unsigned NUM_JUNCTIONS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  in_req_t  req_i,
  input  logic     cfg_we_i,
  input  cost_t    cfg_wdata_i,
  output logic     res_valid_o,
  output out_res_t res_o
);

  localparam int unsigned NJ    = (NUM_JUNCTIONS < 16) ? NUM_JUNCTIONS : 16;
  localparam int unsigned JW    = $clog2(NJ);
  localparam int unsigned DEPTH = 1 << (2 * JW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_BACK  = 3'd3;

  logic [2:0]    state_q, state_d;
  logic [JW-1:0] col_q, col_d;
  logic          pick_q, pick_d;
  jid_t          src_q, src_d;
  jid_t          best_q, best_d;
  cost_t         bestd_q, bestd_d;
  jid_t          cur_q, cur_d;
  cost_t         mask_q;
  logic          tok0_q, tok0_d;
  logic          rv_q, rv_d;
  out_res_t      res_q, res_d;

  logic          accept;
  logic          from_ok, to_ok;
  ctl_t          ctl;

  cost_t         mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  cost_t         rdata_q;
  logic          rvld_q;
  logic [JW-1:0] wa, wb, ra, rb;
  logic [2*JW-1:0] waddr, raddr;
  logic          wen;

  logic  [NJ-1:0] tok;
  link_t          link [NJ];
  jid_t           parent [NJ];
  link_t          last;
  jid_t           par_cur;

  assign accept  = start && !busy;
  assign from_ok = {1'b0, req_i.from_junction} < 5'(NJ);
  assign to_ok   = {1'b0, req_i.to_junction} < 5'(NJ);

  // Cost store addresses: one entry per unordered junction pair.
  always_comb begin
    wa    = req_i.from_junction[JW-1:0];
    wb    = req_i.to_junction[JW-1:0];
    waddr = (wa < wb) ? {wa, wb} : {wb, wa};
    ra    = best_q[JW-1:0];
    rb    = col_q;
    raddr = (ra < rb) ? {ra, rb} : {rb, ra};
    wen   = accept && (req_i.req_type == REQ_WRITE) && from_ok && to_ok;
  end

  // Cost store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= req_i.road_cost;
    end
    rdata_q <= mem[raddr];
  end

  // Entry valid bits; an unwritten entry reads as no road.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wen) begin
        vld_q[waddr] <= 1'b1;
      end
      rvld_q <= vld_q[raddr];
    end
  end

  // Unit mask register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= RSU_RESET;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  assign last    = link[NJ-1];
  assign par_cur = parent[cur_q[JW-1:0]];

  // Sequencer: rounds of sweeps, unit pick, then backtrack.
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    pick_d  = pick_q;
    src_d   = src_q;
    best_d  = best_q;
    bestd_d = bestd_q;
    cur_d   = cur_q;
    tok0_d  = 1'b0;
    rv_d    = 1'b0;
    res_d   = res_q;
    ctl     = '0;
    ctl.bestd      = bestd_q;
    ctl.pick       = pick_q;
    ctl.src        = src_q;
    ctl.settle_idx = best_q;
    ctl.cost       = rvld_q ? rdata_q : NO_ROAD;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.req_type == REQ_QUERY)) begin
          if (from_ok) begin
            ctl.init       = 1'b1;
            ctl.settle     = 1'b1;
            ctl.src        = req_i.from_junction;
            ctl.settle_idx = req_i.from_junction;
            src_d   = req_i.from_junction;
            best_d  = req_i.from_junction;
            bestd_d = '0;
            pick_d  = 1'b0;
            col_d   = '0;
            state_d = ST_SWEEP;
          end else begin
            rv_d  = 1'b1;
            res_d = '{next_junction: '0, found: 1'b0};
          end
        end
      end
      ST_SWEEP: begin
        tok0_d = (col_q == '0);
        col_d  = col_q + 1'b1;
        if (col_q == JW'(NJ - 1)) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (tok[NJ-1]) begin
          col_d = '0;
          if (!pick_q) begin
            if (last.dval == NO_ROAD) begin
              pick_d  = 1'b1;
              state_d = ST_SWEEP;
            end else begin
              ctl.settle     = 1'b1;
              ctl.settle_idx = last.idx;
              best_d  = last.idx;
              bestd_d = last.dval;
              state_d = ST_SWEEP;
            end
          end else if (last.dval == NO_ROAD) begin
            rv_d    = 1'b1;
            res_d   = '{next_junction: '0, found: 1'b0};
            state_d = ST_IDLE;
          end else begin
            cur_d   = last.idx;
            state_d = ST_BACK;
          end
        end
      end
      ST_BACK: begin
        if ((cur_q == src_q) || (par_cur == src_q)) begin
          rv_d    = 1'b1;
          res_d   = '{next_junction: cur_q, found: 1'b1};
          state_d = ST_IDLE;
        end else begin
          cur_d = par_cur;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tok0_q  <= 1'b0;
      rv_q    <= 1'b0;
      pick_q  <= 1'b0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      tok0_q  <= tok0_d;
      rv_q    <= rv_d;
      pick_q  <= pick_d;
      col_q   <= col_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    best_q  <= best_d;
    bestd_q <= bestd_d;
    cur_q   <= cur_d;
    res_q   <= res_d;
  end

  // Chain of junction cells.
  for (genvar n = 0; n < NJ; n++) begin : g_cell
    logic  tin;
    link_t lin;
    if (n == 0) begin : g_head
      assign tin = tok0_q;
      assign lin = '{idx: '0, dval: NO_ROAD};
    end else begin : g_body
      assign tin = tok[n-1];
      assign lin = link[n-1];
    end
    spn_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (jid_t'(n)),
      .rsu_i    (mask_q[n]),
      .ctl_i    (ctl),
      .tok_i    (tin),
      .link_i   (lin),
      .tok_o    (tok[n]),
      .link_o   (link[n]),
      .parent_o (parent[n])
    );
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  // A query is either under way or answered in the next cycle.
  a_query_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.req_type == REQ_QUERY) |=> busy || res_valid_o)
    else $error("query neither started nor answered");

  // At most one cell holds the sweep token.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok, tok0_q}) || $onehot0(tok))
    else $error("more than one active cell");

  // Backtracking only follows the unit pick sweep.
  a_back_after_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BACK) |-> pick_q)
    else $error("backtrack without unit pick");

  // A found hop is a real junction.
  a_hop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.found |-> ({1'b0, res_o.next_junction} < 5'(NJ)))
    else $error("hop out of range");
`endif

endmodule

FILE: dv/shortest_path_next_hop_tb.sv
// ----------------------------------------------------------------------------
// shortest_path_next_hop_tb: self-checking bench for the next-hop search
// Drives road cost writes and next-hop queries through the command port,
// keeps its own copy of the cost matrix and unit mask, predicts each query
// with Dijkstra, and checks every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module shortest_path_next_hop_tb;
  import spn_pkg::*;

  localparam int unsigned NJ        = 16;
  localparam int unsigned MAX_CYCLE = 2000000;

  // Scoreboard: road cost copy, unit mask, and queue of predicted hops.
  class hop_scoreboard;
    cost_t    roads [NJ][NJ];
    cost_t    units;
    out_res_t pending [$];
    int       errors;

    function void clear();
      foreach (roads[i, j]) roads[i][j] = NO_ROAD;
      units  = RSU_RESET;
      errors = 0;
    endfunction

    function out_res_t route(jid_t src);
      cost_t    dv [NJ];
      int       par [NJ];
      bit       done [NJ];
      int       best;
      cost_t    bestd;
      cost_t    d;
      int       sum;
      out_res_t r;
      for (int i = 0; i < NJ; i++) begin
        dv[i]   = NO_ROAD;
        par[i]  = src;
        done[i] = 1'b0;
      end
      dv[src] = '0;
      for (int k = 0; k < NJ; k++) begin
        best  = NJ;
        bestd = NO_ROAD;
        for (int i = 0; i < NJ; i++) begin
          if (!done[i] && dv[i] < bestd) begin
            bestd = dv[i];
            best  = i;
          end
        end
        if (best == NJ) break;
        done[best] = 1'b1;
        for (int n = 0; n < NJ; n++) begin
          if (!done[n] && roads[best][n] != NO_ROAD) begin
            sum = int'(bestd) + int'(roads[best][n]);
            d   = (sum >= int'(NO_ROAD)) ? NO_ROAD : cost_t'(sum);
            if (d < dv[n]) begin
              dv[n]  = d;
              par[n] = best;
            end
          end
        end
      end
      best  = NJ;
      bestd = NO_ROAD;
      for (int i = 0; i < NJ; i++) begin
        if (units[i] && dv[i] < bestd) begin
          bestd = dv[i];
          best  = i;
        end
      end
      r = '0;
      if (best != NJ) begin
        // Walk the parents back to the hop right after the source.
        for (int k = 0; k < NJ && best != src && par[best] != src; k++)
          best = par[best];
        r.next_junction = jid_t'(best);
        r.found         = 1'b1;
      end
      return r;
    endfunction

    function void note_request(in_req_t rq);
      if (rq.req_type == REQ_WRITE) begin
        roads[rq.from_junction][rq.to_junction] = rq.road_cost;
        roads[rq.to_junction][rq.from_junction] = rq.road_cost;
      end else begin
        pending.insert(pending.size(), route(rq.from_junction));
      end
    endfunction

    function void check_result(out_res_t got);
      out_res_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result: next_junction %0d found %0d",
               got.next_junction, got.found);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.next_junction !== exp_r.next_junction) begin
        $error("next_junction mismatch: expected %0d actual %0d",
               exp_r.next_junction, got.next_junction);
        errors++;
      end
      if (got.found !== exp_r.found) begin
        $error("found mismatch: expected %0d actual %0d", exp_r.found, got.found);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  in_req_t  req_i;
  logic     cfg_we_i;
  cost_t    cfg_wdata_i;
  logic     res_valid_o;
  out_res_t res_o;

  hop_scoreboard sb;
  int unsigned   cycle_count;
  int unsigned   burst_left;

  shortest_path_next_hop #(.NUM_JUNCTIONS(NJ)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result monitor; the block cannot be stalled, so every strobe is taken.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Issue one request and hold it until the block takes it. Start stays high
  // after the accept so that the next request of a burst follows at once.
  task automatic send_request(in_req_t rq);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(rq);
  endtask

  // Drop start right after an accept, before any wait.
  task automatic go_idle();
    start <= 1'b0;
  endtask

  task automatic write_road(int a, int b, cost_t c);
    in_req_t rq;
    rq.req_type      = REQ_WRITE;
    rq.from_junction = jid_t'(a);
    rq.to_junction   = jid_t'(b);
    rq.road_cost     = c;
    send_request(rq);
  endtask

  task automatic query_hop(int src);
    in_req_t rq;
    rq.req_type      = REQ_QUERY;
    rq.from_junction = jid_t'(src);
    rq.to_junction   = jid_t'($urandom_range(0, 15));
    rq.road_cost     = cost_t'($urandom_range(0, 65535));
    send_request(rq);
  endtask

  // Let the block drain, then pause past the query latency.
  task automatic drain();
    go_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_units(cost_t m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.units = m;
  endtask

  function automatic cost_t rand_cost();
    case ($urandom_range(0, 5))
      0:       return NO_ROAD;
      1:       return '0;
      2:       return cost_t'($urandom_range(16'hFF00, 16'hFFFE));
      default: return cost_t'($urandom_range(1, 16'h3000));
    endcase
  endfunction

  initial begin
    cost_t masks [5];
    sb          = new();
    sb.clear();
    cycle_count = 0;
    burst_left  = 0;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty graph, a chain, source as unit, saturation, self road.
    query_hop(0);
    query_hop(3);
    write_road(0, 1, 16'h1000);
    write_road(1, 2, '0);
    write_road(2, 3, 16'h0800);
    write_road(5, 5, 16'h0001);
    write_road(15, 14, 16'hFFFE);
    write_road(14, 3, 16'h0001);
    query_hop(0);
    query_hop(2);
    query_hop(15);
    query_hop(14);
    query_hop(5);
    write_road(4, 3, 16'h8000);
    write_road(4, 6, 16'h7FFF);
    query_hop(6);
    write_road(0, 1, NO_ROAD);
    query_hop(0);
    set_units(16'hFFFF);
    query_hop(7);
    query_hop(2);
    set_units(16'h0000);
    query_hop(1);
    set_units(16'h8001);
    query_hop(14);

    // Random phases over several unit masks.
    masks = '{16'h0008, 16'h8001, 16'h0000, 16'hFFFF, 16'h0000};
    for (int ph = 0; ph < 5; ph++) begin
      set_units(ph == 4 ? cost_t'($urandom_range(0, 65535)) : masks[ph]);
      for (int k = 0; k < 80; k++) begin
        if ($urandom_range(0, 2) == 0)
          write_road($urandom_range(0, 15), $urandom_range(0, 15), rand_cost());
        else
          query_hop($urandom_range(0, 15));
        if (k == 40) begin
          // Hold off until everything in flight has come back.
          go_idle();
          @(posedge clk_i);
          while (sb.pending.size() != 0) @(posedge clk_i);
          burst_left = 0;
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
